// ===== rtl/lfc_pkg.sv =====
// ============================================================================
// lfc_pkg: lift floor controller shared definitions
// Floor geometry, field widths, motion and report codes, register map and
// the floor mark decode used by the controller.
// ============================================================================
package lfc_pkg;

    // Building geometry
    localparam int NUM_FLOORS    = 5;
    localparam int BOTTOM_HEIGHT = 15;
    localparam int FLOOR_SPACING = 30;
    localparam int TOP_HEIGHT    = BOTTOM_HEIGHT + (NUM_FLOORS - 1) * FLOOR_SPACING;

    // Field widths
    localparam int HEIGHT_W = 8;
    localparam int FLOOR_W  = 4;
    localparam int STEP_W   = 5;
    localparam int WAIT_W   = 16;
    localparam int REPORT_W = 2;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(5);
    localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(100);

    // Register map (word index taken from paddr[2])
    localparam logic REG_STEP_SIZE  = 1'b0;
    localparam logic REG_WAIT_TICKS = 1'b1;

    // Request kinds carried on the input tuser bit
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        MOT_STAND = 2'd0,
        MOT_UP    = 2'd1,
        MOT_DOWN  = 2'd2
    } t_motion;

    typedef enum logic [REPORT_W-1:0] {
        RPT_NONE   = 2'd0,
        RPT_FLOOR  = 2'd1,
        RPT_FINISH = 2'd2
    } t_report;

    localparam logic [FLOOR_W-1:0]  FLOOR_ONE   = FLOOR_W'(1);
    localparam logic [FLOOR_W-1:0]  FLOOR_NONE  = FLOOR_W'(0);
    localparam logic [FLOOR_W-1:0]  FLOOR_TOP   = FLOOR_W'(NUM_FLOORS);
    localparam logic [HEIGHT_W-1:0] HEIGHT_BOT  = HEIGHT_W'(BOTTOM_HEIGHT);
    localparam logic [HEIGHT_W-1:0] HEIGHT_TOP  = HEIGHT_W'(TOP_HEIGHT);

    // Floor whose mark sits exactly at height h, zero if none
    function automatic logic [FLOOR_W-1:0] floor_at(input logic [HEIGHT_W-1:0] h);
        logic [FLOOR_W-1:0] f_hit;
        f_hit = FLOOR_NONE;
        for (int f = 1; f <= NUM_FLOORS; f++) begin
            if (h == HEIGHT_W'(BOTTOM_HEIGHT + (f - 1) * FLOOR_SPACING)) begin
                f_hit = FLOOR_W'(f);
            end
        end
        return f_hit;
    endfunction

endpackage

// ===== rtl/lift_floor_controller_top.sv =====
// ============================================================================
// lift_floor_controller_top: single-car lift controller
// Steps the car state once per accepted request and emits one status
// result for each, with an APB port for step size and dwell length.
// ============================================================================
// Usage:
//   Input stream s_axis: tuser selects the request kind (0 = time tick,
//   1 = floor request), tdata[3:0] carries the requested floor. Every
//   accepted request produces exactly one result on m_axis.
//   Output stream m_axis: tdata holds car height, motion, arrived floor and
//   the dwell flag; tuser holds the report kind.
//   A result is valid in the cycle after input acceptance. The state update
//   is a single pass of short logic into the state and result registers, so
//   one request is taken every cycle while the receiver is not stalling.
//   The result register is the only buffer: s_axis_tready is high while the
//   result register is empty or being emptied in the same cycle, so a stalled
//   receiver holds the input side after one waiting result.
//   Reset (synchronous, active low) puts the car at the bottom floor,
//   standing, destination floor 1, no dwell; step size 5 and dwell 100.
//   Configuration writes through APB are meant for idle periods only;
//   pready is tied high and reads return the register contents.
// ============================================================================
module lift_floor_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] floor_number, [7:4] zero
    input  logic        s_axis_tuser,   // [0] mode
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] car_height, [9:8] motion,
                                        // [13:10] arrived_floor, [14] waiting,
                                        // [15] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] report_kind
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [lfc_pkg::STEP_W-1:0]   r_step_size;
    logic [lfc_pkg::WAIT_W-1:0]   r_wait_ticks;

    // Car state
    logic [lfc_pkg::FLOOR_W-1:0]  r_dest, n_dest;
    logic [lfc_pkg::HEIGHT_W-1:0] r_height, n_height;
    lfc_pkg::t_motion             r_motion, n_motion;
    logic [lfc_pkg::WAIT_W-1:0]   r_dwell_cnt, n_dwell_cnt;
    logic                         r_dwelling, n_dwelling;

    // Result register
    logic                         r_out_valid;
    logic [lfc_pkg::FLOOR_W-1:0]  r_out_arrived;
    lfc_pkg::t_report             r_out_report;

    logic                         w_in_accept;
    logic                         w_cfg_write;
    logic [lfc_pkg::FLOOR_W-1:0]  w_req_floor;
    logic [lfc_pkg::FLOOR_W-1:0]  n_arrived;
    lfc_pkg::t_report             n_report;
    logic [lfc_pkg::HEIGHT_W-1:0] w_step_ext;
    logic [lfc_pkg::HEIGHT_W-1:0] w_gap_up;
    logic [lfc_pkg::HEIGHT_W-1:0] w_gap_down;
    logic [lfc_pkg::WAIT_W-1:0]   w_dwell_dec;

    // Handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign w_cfg_write   = psel && penable && pwrite && pready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= lfc_pkg::STEP_RESET;
            r_wait_ticks <= lfc_pkg::WAIT_RESET;
        end else if (w_cfg_write) begin
            if (paddr[2] == lfc_pkg::REG_STEP_SIZE) begin
                r_step_size <= pwdata[lfc_pkg::STEP_W-1:0];
            end else begin
                r_wait_ticks <= pwdata[lfc_pkg::WAIT_W-1:0];
            end
        end
    end

    // Register readback
    always_comb begin
        if (paddr[2] == lfc_pkg::REG_STEP_SIZE) begin
            prdata = 32'(r_step_size);
        end else begin
            prdata = 32'(r_wait_ticks);
        end
    end

    assign w_req_floor = s_axis_tdata[lfc_pkg::FLOOR_W-1:0];
    assign w_step_ext  = lfc_pkg::HEIGHT_W'(r_step_size);
    assign w_gap_up    = lfc_pkg::HEIGHT_TOP - r_height;
    assign w_gap_down  = r_height - lfc_pkg::HEIGHT_BOT;
    assign w_dwell_dec = (r_dwell_cnt != '0) ?
                         r_dwell_cnt - lfc_pkg::WAIT_W'(1) : r_dwell_cnt;

    // Next car state and result for the offered request
    always_comb begin
        n_dest      = r_dest;
        n_height    = r_height;
        n_motion    = r_motion;
        n_dwell_cnt = r_dwell_cnt;
        n_dwelling  = r_dwelling;
        n_arrived   = lfc_pkg::FLOOR_NONE;
        n_report    = lfc_pkg::RPT_NONE;

        if (s_axis_tuser == lfc_pkg::MODE_REQUEST) begin
            // Take a floor request unless dwelling or out of range
            if (!r_dwelling && w_req_floor >= lfc_pkg::FLOOR_ONE &&
                w_req_floor <= lfc_pkg::FLOOR_TOP) begin
                n_dest   = w_req_floor;
                n_motion = (w_req_floor == lfc_pkg::FLOOR_ONE) ?
                           lfc_pkg::MOT_DOWN : lfc_pkg::MOT_UP;
            end
        end else if (r_dwelling) begin
            // Count the dwell down, then head back to floor 1
            n_dwell_cnt = w_dwell_dec;
            if (w_dwell_dec == '0) begin
                n_dwelling = 1'b0;
                n_dest     = lfc_pkg::FLOOR_ONE;
                n_motion   = lfc_pkg::MOT_DOWN;
            end
        end else begin
            // Move the car, saturating at the shaft ends
            case (r_motion)
                lfc_pkg::MOT_DOWN: begin
                    if (r_height > lfc_pkg::HEIGHT_BOT) begin
                        n_height = (w_gap_down > w_step_ext) ?
                                   r_height - w_step_ext : lfc_pkg::HEIGHT_BOT;
                    end else begin
                        n_motion = lfc_pkg::MOT_STAND;
                    end
                end
                lfc_pkg::MOT_UP: begin
                    if (r_height < lfc_pkg::HEIGHT_TOP) begin
                        n_height = (w_gap_up > w_step_ext) ?
                                   r_height + w_step_ext : lfc_pkg::HEIGHT_TOP;
                    end else begin
                        n_motion = lfc_pkg::MOT_STAND;
                    end
                end
                default: begin
                    n_height = r_height;
                end
            endcase

            // Detect a floor mark landing
            if (n_height != r_height) begin
                n_arrived = lfc_pkg::floor_at(n_height);
                if (n_arrived == lfc_pkg::FLOOR_ONE) begin
                    n_report = lfc_pkg::RPT_FLOOR;
                    if (r_dest == lfc_pkg::FLOOR_ONE) begin
                        n_motion = lfc_pkg::MOT_STAND;
                    end
                end else if (n_arrived != lfc_pkg::FLOOR_NONE) begin
                    if (n_arrived == r_dest) begin
                        n_report = lfc_pkg::RPT_FINISH;
                        if (r_wait_ticks == '0) begin
                            n_dest   = lfc_pkg::FLOOR_ONE;
                            n_motion = lfc_pkg::MOT_DOWN;
                        end else begin
                            n_motion    = lfc_pkg::MOT_STAND;
                            n_dwelling  = 1'b1;
                            n_dwell_cnt = r_wait_ticks;
                        end
                    end else begin
                        n_report = lfc_pkg::RPT_FLOOR;
                    end
                end
            end
        end
    end

    // Advance car state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest      <= lfc_pkg::FLOOR_ONE;
            r_height    <= lfc_pkg::HEIGHT_BOT;
            r_motion    <= lfc_pkg::MOT_STAND;
            r_dwell_cnt <= '0;
            r_dwelling  <= 1'b0;
        end else if (w_in_accept) begin
            r_dest      <= n_dest;
            r_height    <= n_height;
            r_motion    <= n_motion;
            r_dwell_cnt <= n_dwell_cnt;
            r_dwelling  <= n_dwelling;
        end
    end

    // Hold the result valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture result fields that are not part of the car state
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out_arrived <= n_arrived;
            r_out_report  <= n_report;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_dwelling, r_out_arrived, r_motion, r_height};
    assign m_axis_tuser  = r_out_report;

    // Dwelling car never moves
    a_dwell_stands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dwelling |-> (r_motion == lfc_pkg::MOT_STAND))
        else $error("car in motion while dwelling");

    // Car stays inside the shaft
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_height >= lfc_pkg::HEIGHT_BOT) && (r_height <= lfc_pkg::HEIGHT_TOP))
        else $error("car height outside shaft");

    // Job finished leaves the car dwelling or heading down
    a_finish_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_report == lfc_pkg::RPT_FINISH) |->
        (r_dwelling || r_motion == lfc_pkg::MOT_DOWN))
        else $error("finish report without dwell or return");

    // Result not taken is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_in_accept)
        else $error("result overwritten while stalled");

    // Accepted request always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule

// ===== tb/tb_lift_floor_controller_top.sv =====
// ============================================================================
// tb_lift_floor_controller_top: self-checking bench for the lift controller
// Drives ticks and floor calls into the input stream and predicts every car
// status in a model of its own. Each status taken from the output stream is
// compared field by field. A directed table runs first, then random phases
// under several step and dwell settings and idle patterns, and at the end
// one long dwell with calls arriving during it.
// ============================================================================
module tb_lift_floor_controller_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 110;
    localparam int NUM_PHASES   = 6;
    localparam int DIR_ROWS     = 30;
    localparam int LONG_WAIT    = 200;

    // Step and dwell settings for the random phases
    localparam int PHASE_STEP [NUM_PHASES] = '{5, 30, 1, 7, 31, 15};
    localparam int PHASE_WAIT [NUM_PHASES] = '{3, 0, 1, 2, 4, 6};

    typedef struct packed {
        logic [7:0]       height;
        lfc_pkg::t_motion motion;
        logic [3:0]       arrived;
        lfc_pkg::t_report report;
        logic             waiting;
    } t_car_status;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_STEP,
        ROW_SET_WAIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        mode;
        logic [15:0] arg;      // floor for an item, value for a register
        logic        typed;
        t_car_status status;
    } t_stim_row;

    localparam t_car_status NOT_TYPED = '0;
    localparam t_car_status AT_BOTTOM =
        '{lfc_pkg::HEIGHT_BOT, lfc_pkg::MOT_STAND, lfc_pkg::FLOOR_NONE,
          lfc_pkg::RPT_NONE, 1'b0};
    localparam t_car_status AT_BOTTOM_DOWN =
        '{lfc_pkg::HEIGHT_BOT, lfc_pkg::MOT_DOWN, lfc_pkg::FLOOR_NONE,
          lfc_pkg::RPT_NONE, 1'b0};

    localparam logic M_TICK = lfc_pkg::MODE_TICK;
    localparam logic M_REQ  = lfc_pkg::MODE_REQUEST;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [3:0] floor_number, [7:4] zero
    logic        s_axis_tuser  = 1'b0;  // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] car_height, [9:8] motion,
                                        // [13:10] arrived_floor, [14] waiting
    logic [1:0]  m_axis_tuser;          // [1:0] report_kind
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted car state and register copies
    logic [3:0]       car_dest;
    logic [7:0]       car_height;
    logic [7:0]       car_prev;
    lfc_pkg::t_motion car_motion;
    logic [15:0]      dwell_left;
    logic             car_dwelling;
    logic [4:0]       step_cfg;
    logic [15:0]      wait_cfg;

    t_car_status status_q [$];
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          sender_gap_pct = 0;
    int          recv_stall_pct = 0;

    t_stim_row directed_rows [DIR_ROWS] = '{
        // after reset, ignored calls, floor 1 call at the bottom
        '{ROW_ITEM, M_TICK, 16'd0,  1'b1, AT_BOTTOM},
        '{ROW_ITEM, M_REQ,  16'd0,  1'b1, AT_BOTTOM},
        '{ROW_ITEM, M_REQ,  16'd15, 1'b1, AT_BOTTOM},
        '{ROW_ITEM, M_REQ,  16'd1,  1'b1, AT_BOTTOM_DOWN},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b1, AT_BOTTOM},
        // full-floor steps, short dwell, call ignored while dwelling
        '{ROW_SET_STEP, M_TICK, 16'd30, 1'b0, NOT_TYPED},
        '{ROW_SET_WAIT, M_TICK, 16'd2,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_REQ,  16'd3,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_REQ,  16'd5,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        // zero dwell heads straight back down
        '{ROW_SET_WAIT, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_REQ,  16'd2,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        // step that misses the marks on the way up
        '{ROW_SET_STEP, M_TICK, 16'd31, 1'b0, NOT_TYPED},
        '{ROW_ITEM, M_REQ,  16'd5,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        // call below the car still goes up, saturating at the top
        '{ROW_ITEM, M_REQ,  16'd2,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        // zero step never moves the car
        '{ROW_SET_STEP, M_TICK, 16'd0,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_REQ,  16'd1,  1'b0, NOT_TYPED},
        '{ROW_ITEM, M_TICK, 16'd0,  1'b0, NOT_TYPED}
    };

    lift_floor_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the receiver at the current rate
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Advance the predicted car by one request and return its status
    function automatic t_car_status advance_car(input logic mode, input logic [3:0] fl);
        t_car_status st;
        int          off;
        logic [3:0]  hit;
        hit       = lfc_pkg::FLOOR_NONE;
        st.report = lfc_pkg::RPT_NONE;
        if (mode == lfc_pkg::MODE_REQUEST) begin
            if (!car_dwelling && fl >= lfc_pkg::FLOOR_ONE && fl <= lfc_pkg::FLOOR_TOP) begin
                car_dest = fl;
                if (fl == lfc_pkg::FLOOR_ONE) begin
                    car_motion = lfc_pkg::MOT_DOWN;
                end else begin
                    car_motion = lfc_pkg::MOT_UP;
                end
            end
        end else if (car_dwelling) begin
            // count the dwell down, then head for floor 1
            if (dwell_left != 0) begin
                dwell_left = dwell_left - 16'd1;
            end
            if (dwell_left == 0) begin
                car_dwelling = 1'b0;
                car_dest     = lfc_pkg::FLOOR_ONE;
                car_motion   = lfc_pkg::MOT_DOWN;
            end
        end else begin
            // move, saturating at both ends, and stand at an end
            if (car_motion == lfc_pkg::MOT_DOWN) begin
                if (car_height > lfc_pkg::HEIGHT_BOT) begin
                    if (int'(car_height) - lfc_pkg::BOTTOM_HEIGHT > int'(step_cfg)) begin
                        car_height = car_height - 8'(step_cfg);
                    end else begin
                        car_height = lfc_pkg::HEIGHT_BOT;
                    end
                end else begin
                    car_motion = lfc_pkg::MOT_STAND;
                end
            end else if (car_motion == lfc_pkg::MOT_UP) begin
                if (car_height < lfc_pkg::HEIGHT_TOP) begin
                    if (lfc_pkg::TOP_HEIGHT - int'(car_height) > int'(step_cfg)) begin
                        car_height = car_height + 8'(step_cfg);
                    end else begin
                        car_height = lfc_pkg::HEIGHT_TOP;
                    end
                end else begin
                    car_motion = lfc_pkg::MOT_STAND;
                end
            end
            // detect a floor mark on a changed height
            if (car_height != car_prev) begin
                off = int'(car_height) - lfc_pkg::BOTTOM_HEIGHT;
                if (off >= 0 && int'(car_height) <= lfc_pkg::TOP_HEIGHT
                        && off % lfc_pkg::FLOOR_SPACING == 0) begin
                    hit = 4'(off / lfc_pkg::FLOOR_SPACING + 1);
                end
                car_prev = car_height;
                if (hit == lfc_pkg::FLOOR_ONE) begin
                    st.report = lfc_pkg::RPT_FLOOR;
                    if (car_dest == lfc_pkg::FLOOR_ONE) begin
                        car_motion = lfc_pkg::MOT_STAND;
                    end
                end else if (hit != lfc_pkg::FLOOR_NONE) begin
                    if (hit == car_dest) begin
                        st.report  = lfc_pkg::RPT_FINISH;
                        car_motion = lfc_pkg::MOT_STAND;
                        if (wait_cfg == 0) begin
                            car_dest   = lfc_pkg::FLOOR_ONE;
                            car_motion = lfc_pkg::MOT_DOWN;
                        end else begin
                            car_dwelling = 1'b1;
                            dwell_left   = wait_cfg;
                        end
                    end else begin
                        st.report = lfc_pkg::RPT_FLOOR;
                    end
                end
            end
        end
        st.height  = car_height;
        st.motion  = car_motion;
        st.arrived = hit;
        st.waiting = car_dwelling;
        return st;
    endfunction

    // Drive one request, hold it until taken, and queue its status
    task automatic send_item(input logic mode, input logic [3:0] fl,
                             input logic typed, input t_car_status typed_status);
        t_car_status got;
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0000, fl};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = advance_car(mode, fl);
        if (typed) begin
            status_q.push_back(typed_status);
        end else begin
            status_q.push_back(got);
        end
    endtask

    task automatic send_tick();
        send_item(lfc_pkg::MODE_TICK, 4'($urandom_range(15)), 1'b0, NOT_TYPED);
    endtask

    // Drop valid and wait until every status is back and the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write: setup then access, done when pready is seen
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lfc_pkg::REG_STEP_SIZE) begin
            step_cfg = val[4:0];
        end else begin
            wait_cfg = val[15:0];
        end
    endtask

    // Check each status taken against the oldest prediction
    always @(posedge i_clk) begin
        t_car_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status, expected none, got tdata=%h tuser=%h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = status_q.pop_front();
                if (m_axis_tdata[7:0] !== want.height) begin
                    $display("%0t: car_height expected %0d, got %0d",
                             $time, want.height, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[9:8] !== want.motion) begin
                    $display("%0t: motion expected %0d, got %0d",
                             $time, want.motion, m_axis_tdata[9:8]);
                    mismatches++;
                end
                if (m_axis_tdata[13:10] !== want.arrived) begin
                    $display("%0t: arrived_floor expected %0d, got %0d",
                             $time, want.arrived, m_axis_tdata[13:10]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.report) begin
                    $display("%0t: report_kind expected %0d, got %0d",
                             $time, want.report, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[14] !== want.waiting) begin
                    $display("%0t: waiting expected %0d, got %0d",
                             $time, want.waiting, m_axis_tdata[14]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        int        r;

        car_dest     = lfc_pkg::FLOOR_ONE;
        car_height   = lfc_pkg::HEIGHT_BOT;
        car_prev     = lfc_pkg::HEIGHT_BOT;
        car_motion   = lfc_pkg::MOT_STAND;
        dwell_left   = '0;
        car_dwelling = 1'b0;
        step_cfg     = lfc_pkg::STEP_RESET;
        wait_cfg     = lfc_pkg::WAIT_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with light sender and heavy receiver idling
        sender_gap_pct = 11;
        recv_stall_pct = 56;
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_SET_STEP: begin
                    settle();
                    write_reg(lfc_pkg::REG_STEP_SIZE, 32'(row.arg));
                end
                ROW_SET_WAIT: begin
                    settle();
                    write_reg(lfc_pkg::REG_WAIT_TICKS, 32'(row.arg));
                end
                default: begin
                    send_item(row.mode, row.arg[3:0], row.typed, row.status);
                end
            endcase
        end

        // Random phases: mostly ticks and valid calls, some calls that may be out of range
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(lfc_pkg::REG_STEP_SIZE, 32'(PHASE_STEP[p]));
            write_reg(lfc_pkg::REG_WAIT_TICKS, 32'(PHASE_WAIT[p]));
            case (p / 2)
                0: begin
                    sender_gap_pct = 11;
                    recv_stall_pct = 56;
                end
                1: begin
                    sender_gap_pct = 56;
                    recv_stall_pct = 11;
                end
                default: begin
                    sender_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 72) begin
                    send_tick();
                end else if (r < 94) begin
                    send_item(lfc_pkg::MODE_REQUEST,
                              4'($urandom_range(lfc_pkg::NUM_FLOORS, 1)),
                              1'b0, NOT_TYPED);
                end else begin
                    send_item(lfc_pkg::MODE_REQUEST, 4'($urandom_range(15)),
                              1'b0, NOT_TYPED);
                end
            end
        end

        // Long dwell: park at the bottom, run to the top floor, wait it out
        settle();
        write_reg(lfc_pkg::REG_STEP_SIZE, 32'd30);
        write_reg(lfc_pkg::REG_WAIT_TICKS, 32'(LONG_WAIT));
        while (car_dwelling) send_tick();
        send_item(lfc_pkg::MODE_REQUEST, lfc_pkg::FLOOR_ONE, 1'b0, NOT_TYPED);
        while (car_motion != lfc_pkg::MOT_STAND) send_tick();
        send_item(lfc_pkg::MODE_REQUEST, lfc_pkg::FLOOR_TOP, 1'b0, NOT_TYPED);
        while (!car_dwelling) send_tick();
        while (car_dwelling) begin
            if ($urandom_range(63) == 0) begin
                send_item(lfc_pkg::MODE_REQUEST, 4'($urandom_range(15)),
                          1'b0, NOT_TYPED);
            end else begin
                send_tick();
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lfc_pkg.sv
rtl/lift_floor_controller_top.sv
tb/tb_lift_floor_controller_top.sv
